>>> sv/pfb_pkg.sv
`timescale 1ns / 1ps

package pfb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int STORE_DEPTH_DEF   = SCREEN_WIDTH_DEF * ((SCREEN_HEIGHT_DEF + 7) / 8);

  typedef logic [1:0] op_t;

  localparam op_t OP_PLOT  = 2'd0;
  localparam op_t OP_BLIT  = 2'd1;
  localparam op_t OP_READ  = 2'd2;
  localparam op_t OP_CLEAR = 2'd3;

endpackage

>>> sv/pfb_if.sv
`timescale 1ns / 1ps

interface pfb_req_if;
  logic              valid;
  logic              ready;
  pfb_pkg::op_t      operation;
  logic signed [8:0] x_pos;
  logic signed [8:0] y_pos;
  logic              pixel_on;
  logic [7:0]        sprite_byte;
  logic [3:0]        bit_count;

  modport source (
    output valid, operation, x_pos, y_pos, pixel_on, sprite_byte, bit_count,
    input  ready
  );
  modport sink (
    input  valid, operation, x_pos, y_pos, pixel_on, sprite_byte, bit_count,
    output ready
  );
endinterface

interface pfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] pair_code;

  modport source (
    output valid, pair_code,
    input  ready
  );
  modport sink (
    input  valid, pair_code,
    output ready
  );
endinterface

>>> sv/page_framebuffer_blitter.sv
`timescale 1ns / 1ps
// Page-layout monochrome framebuffer with plot, blit, read and clear items.
// Channels: req (sink) carries operation, x_pos, y_pos, pixel_on,
// sprite_byte and bit_count; rsp (source) returns one pair_code per item,
// in order, through an output register. Both use valid/ready.
// The frame store is one synchronous RAM of SCREEN_WIDTH * ceil(H/8) bytes,
// one read and one write port, registered read data in the cycle after the address.
// Each item reads its page byte on acceptance; plot and blit write it back
// in S_P0, or in S_P0 and S_P1 when the touched rows span two pages.
// Throughput: one item per cycle while rsp is taken and all touched rows lie
// in one page; a blit or read spanning two pages adds a second RAM read.
// The result enters the output register as the item leaves S_P0 or S_P1.
// Clear: the RAM is swept one byte per cycle over all STORE_DEPTH bytes
// (1024 at 128 x 64), then the result is returned; no item is taken meanwhile.
// Reset: synchronous rst starts the same sweep (no result); req.ready stays
// low until it ends.
// Stall: while rsp is not taken, a finished item holds before its write-back
// and req.ready stays low; nothing is lost or repeated.

module page_framebuffer_blitter #(
  parameter int SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pfb_req_if.sink   req,
  pfb_rsp_if.source rsp
);

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_DEPTH);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_P0   = 2'd2;
  localparam logic [1:0] S_P1   = 2'd3;

  logic [1:0]    state;
  logic [AW-1:0] cnt;
  logic          clr_report;
  logic          out_valid;
  logic [1:0]    out_code;

  logic          op_wr;
  logic [15:0]   mask_r;
  logic [15:0]   data_r;
  logic [AW-1:0] addr0_r;
  logic [AW-1:0] addr1_r;
  logic [2:0]    off_r;
  logic          need1;
  logic [7:0]    byte0;

  logic          x_ok;
  logic [7:0]    row_ok;
  logic [7:0]    en8;
  logic [7:0]    dat8;
  logic [15:0]   mask_in;
  logic [15:0]   data_in;
  logic signed [5:0]  pg;
  logic signed [31:0] pg_off;
  logic [AW-1:0] addr_in;

  logic          ren;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;

  logic [7:0]    merge0;
  logic [7:0]    merge1;
  logic [15:0]   rd16;
  logic [15:0]   sel16;
  logic [1:0]    code_c;

  logic          out_free;
  logic          fin;
  logic          push_item;
  logic          clr_last;
  logic          push_clr;
  logic          accept;

  always_comb begin
    logic [9:0] yi;
    x_ok = !req.x_pos[8] && ({1'b0, req.x_pos[7:0]} < 9'(SCREEN_WIDTH));
    for (int i = 0; i < 8; i++) begin
      yi        = {req.y_pos[8], req.y_pos} + 10'(i);
      row_ok[i] = !yi[9] && (yi[8:0] < 9'(SCREEN_HEIGHT));
    end
    en8  = 8'd0;
    dat8 = 8'd0;
    case (req.operation)
      pfb_pkg::OP_PLOT: begin
        en8  = {7'd0, x_ok && row_ok[0]};
        dat8 = {7'd0, req.pixel_on};
      end
      pfb_pkg::OP_BLIT: begin
        for (int i = 0; i < 8; i++) begin
          en8[i] = x_ok && row_ok[i] && (4'(i) < req.bit_count);
        end
        dat8 = req.sprite_byte;
      end
      pfb_pkg::OP_READ: begin
        en8 = {6'd0, x_ok && row_ok[1], x_ok && row_ok[0]};
      end
      default: begin
        en8  = 8'd0;
        dat8 = 8'd0;
      end
    endcase
    mask_in = {8'd0, en8} << req.y_pos[2:0];
    data_in = {8'd0, dat8} << req.y_pos[2:0];
  end

  assign pg      = req.y_pos[8:3];
  assign pg_off  = 32'(pg) * SCREEN_WIDTH;
  assign addr_in = AW'(pg_off) + AW'(req.x_pos[7:0]);
  assign addr1_r = addr0_r + AW'(SCREEN_WIDTH);

  assign out_free  = !out_valid || rsp.ready;
  assign fin       = (state == S_P0 && !need1) || (state == S_P1);
  assign push_item = fin && out_free;
  assign clr_last  = (state == S_CLR) && (cnt == AW'(STORE_DEPTH - 1));
  assign push_clr  = clr_last && clr_report && out_free;
  assign req.ready = (state == S_IDLE) || push_item;
  assign accept    = req.valid && req.ready;

  assign merge0 = (rdata & ~mask_r[7:0]) | (data_r[7:0] & mask_r[7:0]);
  assign merge1 = (rdata & ~mask_r[15:8]) | (data_r[15:8] & mask_r[15:8]);

  assign ren   = accept || (state == S_P0 && need1);
  assign raddr = accept ? addr_in : addr1_r;

  always_comb begin
    case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = 8'd0;
      end
      S_P0: begin
        we    = op_wr && (|mask_r[7:0]) && (need1 || out_free);
        waddr = addr0_r;
        wdata = merge0;
      end
      S_P1: begin
        we    = op_wr && (|mask_r[15:8]) && out_free;
        waddr = addr1_r;
        wdata = merge1;
      end
      default: begin
        we    = 1'b0;
        waddr = addr0_r;
        wdata = merge0;
      end
    endcase
  end

  assign rd16   = (state == S_P1) ? {rdata, byte0} : {8'd0, rdata};
  assign sel16  = (rd16 & mask_r) >> off_r;
  assign code_c = op_wr ? 2'b00 : sel16[1:0];

  pfb_store #(
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .ren  (ren),
    .raddr(raddr),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      cnt        <= '0;
      clr_report <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push_item || push_clr) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (req.operation == pfb_pkg::OP_CLEAR) begin
          state      <= S_CLR;
          cnt        <= '0;
          clr_report <= 1'b1;
        end else begin
          state <= S_P0;
        end
      end else begin
        case (state)
          S_CLR: begin
            if (!clr_last) begin
              cnt <= cnt + 1'b1;
            end else if (!clr_report || out_free) begin
              state <= S_IDLE;
            end
          end
          S_P0: begin
            if (need1) begin
              state <= S_P1;
            end else if (out_free) begin
              state <= S_IDLE;
            end
          end
          S_P1: begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end
          default: begin
            state <= state;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_item) begin
      out_code <= code_c;
    end else if (push_clr) begin
      out_code <= 2'b00;
    end
    if (accept) begin
      op_wr   <= (req.operation != pfb_pkg::OP_READ);
      mask_r  <= mask_in;
      data_r  <= data_in;
      addr0_r <= addr_in;
      off_r   <= req.y_pos[2:0];
      need1   <= |mask_in[15:8];
    end
    if (state == S_P0) begin
      byte0 <= rdata;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.pair_code = out_code;

endmodule

>>> sv/pfb_store.sv
`timescale 1ns / 1ps

module pfb_store #(
  parameter int  DEPTH = pfb_pkg::STORE_DEPTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          ren,
  input  logic [AW-1:0] raddr,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;
  logic       fwd_hit;
  logic [7:0] fwd_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      mem_q    <= mem[raddr];
      fwd_hit  <= we && (waddr == raddr);
      fwd_data <= wdata;
    end
  end

  assign rdata = fwd_hit ? fwd_data : mem_q;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int SCR_W = pfb_pkg::SCREEN_WIDTH_DEF;
  localparam int SCR_H = pfb_pkg::SCREEN_HEIGHT_DEF;
  localparam int DEPTH = pfb_pkg::STORE_DEPTH_DEF;
  localparam int RANDOM_PER_PHASE = 470;

  typedef struct packed {
    pfb_pkg::op_t      operation;
    logic signed [8:0] x_pos;
    logic signed [8:0] y_pos;
    logic              pixel_on;
    logic [7:0]        sprite_byte;
    logic [3:0]        bit_count;
  } draw_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfb_req_if req_ch ();
  pfb_rsp_if rsp_ch ();

  page_framebuffer_blitter dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  draw_item_t pending_items[$];
  logic [1:0] expected_codes[$];
  draw_item_t cur_item;
  logic [7:0] shadow_frame[DEPTH];
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int fail_count = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic bit pixel_visible(input int x, input int y);
    return x >= 0 && x < SCR_W && y >= 0 && y < SCR_H;
  endfunction

  function automatic void put_pixel(input int x, input int y, input bit v);
    int addr;
    if (!pixel_visible(x, y)) return;
    addr = x + (y / 8) * SCR_W;
    shadow_frame[addr][y % 8] = v;
  endfunction

  function automatic bit get_pixel(input int x, input int y);
    if (!pixel_visible(x, y)) return 1'b0;
    return shadow_frame[x + (y / 8) * SCR_W][y % 8];
  endfunction

  function automatic logic [1:0] predict_pair_code(input draw_item_t it);
    int x;
    int y;
    int cnt;
    logic [1:0] code;
    x = it.x_pos;
    y = it.y_pos;
    code = 2'b00;
    case (it.operation)
      pfb_pkg::OP_PLOT: begin
        put_pixel(x, y, it.pixel_on);
      end
      pfb_pkg::OP_BLIT: begin
        cnt = (it.bit_count > 4'd8) ? 8 : int'(it.bit_count);
        for (int i = 0; i < cnt; i++) put_pixel(x, y + i, it.sprite_byte[i]);
      end
      pfb_pkg::OP_READ: begin
        code = {get_pixel(x, y + 1), get_pixel(x, y)};
      end
      default: begin
        foreach (shadow_frame[a]) shadow_frame[a] = 8'h00;
      end
    endcase
    return code;
  endfunction

  task automatic push_item(input pfb_pkg::op_t op, input int x, input int y, input bit on,
                           input int sprite, input int cnt);
    draw_item_t it;
    it.operation   = op;
    it.x_pos       = 9'(x);
    it.y_pos       = 9'(y);
    it.pixel_on    = on;
    it.sprite_byte = 8'(sprite);
    it.bit_count   = 4'(cnt);
    pending_items.push_back(it);
  endtask

  function automatic draw_item_t random_item();
    draw_item_t it;
    int r;
    int x;
    int y;
    r = $urandom_range(999);
    if (r < 350) it.operation = pfb_pkg::OP_PLOT;
    else if (r < 650) it.operation = pfb_pkg::OP_BLIT;
    else if (r < 994) it.operation = pfb_pkg::OP_READ;
    else it.operation = pfb_pkg::OP_CLEAR;
    r = $urandom_range(99);
    if (r < 40) x = $urandom_range(7);
    else if (r < 80) x = $urandom_range(SCR_W - 1);
    else x = int'($urandom_range(511)) - 256;
    r = $urandom_range(99);
    if (r < 40) y = $urandom_range(15);
    else if (r < 80) y = int'($urandom_range(SCR_H + 8)) - 8;
    else y = int'($urandom_range(511)) - 256;
    it.x_pos       = 9'(x);
    it.y_pos       = 9'(y);
    it.pixel_on    = 1'($urandom_range(1));
    it.sprite_byte = 8'($urandom_range(255));
    if ($urandom_range(99) < 85) it.bit_count = 4'($urandom_range(8, 1));
    else it.bit_count = 4'($urandom_range(15));
    return it;
  endfunction

  always @(posedge clk) begin : drive_req
    draw_item_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) expected_codes.push_back(predict_pair_code(cur_item));
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          cur_item            <= nxt;
          req_ch.valid        <= 1'b1;
          req_ch.operation    <= nxt.operation;
          req_ch.x_pos        <= nxt.x_pos;
          req_ch.y_pos        <= nxt.y_pos;
          req_ch.pixel_on     <= nxt.pixel_on;
          req_ch.sprite_byte  <= nxt.sprite_byte;
          req_ch.bit_count    <= nxt.bit_count;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_rsp
    logic [1:0] want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("unexpected result pair_code=%0d", rsp_ch.pair_code));
        end else begin
          want = expected_codes.pop_front();
          if (rsp_ch.pair_code !== want)
            report_mismatch($sformatf("pair_code got %0d want %0d", rsp_ch.pair_code, want));
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.operation   = pfb_pkg::OP_PLOT;
    req_ch.x_pos       = '0;
    req_ch.y_pos       = '0;
    req_ch.pixel_on    = 1'b0;
    req_ch.sprite_byte = '0;
    req_ch.bit_count   = '0;
    rsp_ch.ready       = 1'b0;
    cur_item           = '0;
    foreach (shadow_frame[a]) shadow_frame[a] = 8'h00;

    push_item(pfb_pkg::OP_PLOT, 0, 0, 1'b1, 8'h5A, 3);
    push_item(pfb_pkg::OP_PLOT, SCR_W - 1, SCR_H - 1, 1'b1, 0, 0);
    push_item(pfb_pkg::OP_READ, 0, 0, 1'b0, 8'hFF, 15);
    push_item(pfb_pkg::OP_READ, SCR_W - 1, SCR_H - 2, 1'b1, 0, 0);
    push_item(pfb_pkg::OP_READ, SCR_W - 1, SCR_H - 1, 1'b0, 0, 0);
    push_item(pfb_pkg::OP_PLOT, -1, 0, 1'b1, 0, 0);
    push_item(pfb_pkg::OP_PLOT, SCR_W, 0, 1'b1, 0, 0);
    push_item(pfb_pkg::OP_PLOT, 0, SCR_H, 1'b1, 0, 0);
    push_item(pfb_pkg::OP_PLOT, -256, -256, 1'b1, 0, 0);
    push_item(pfb_pkg::OP_PLOT, 255, 255, 1'b1, 0, 0);
    push_item(pfb_pkg::OP_BLIT, 3, 5, 1'b1, 8'hA5, 8);
    push_item(pfb_pkg::OP_READ, 3, 7, 1'b0, 0, 0);
    push_item(pfb_pkg::OP_BLIT, 4, -3, 1'b0, 8'hFF, 8);
    push_item(pfb_pkg::OP_READ, 4, -1, 1'b0, 0, 0);
    push_item(pfb_pkg::OP_BLIT, 5, SCR_H - 4, 1'b0, 8'hFF, 8);
    push_item(pfb_pkg::OP_READ, 5, SCR_H - 1, 1'b0, 0, 0);
    push_item(pfb_pkg::OP_BLIT, 6, 8, 1'b1, 8'hFF, 0);
    push_item(pfb_pkg::OP_BLIT, 7, 16, 1'b0, 8'h81, 15);
    push_item(pfb_pkg::OP_READ, 7, 23, 1'b1, 8'hFF, 2);
    push_item(pfb_pkg::OP_PLOT, 3, 6, 1'b0, 8'hFF, 15);
    push_item(pfb_pkg::OP_READ, 3, 5, 1'b1, 0, 0);
    push_item(pfb_pkg::OP_READ, -1, 0, 1'b0, 0, 0);
    push_item(pfb_pkg::OP_CLEAR, 100, -7, 1'b1, 8'h3C, 9);
    push_item(pfb_pkg::OP_READ, 0, 0, 1'b0, 0, 0);
    push_item(pfb_pkg::OP_READ, 3, 7, 1'b0, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      while (pending_items.size() != 0) @(posedge clk);
      case (phase)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 54; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 54; end
        default: begin send_idle_pct = 12; rsp_stall_pct = 12; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) pending_items.push_back(random_item());
    end

    while (pending_items.size() != 0 || req_ch.valid || expected_codes.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
